>>> hdl/tts_pkg.sv
// Package for the text terminal screen: geometry, character codes, operation codes
// and the request/response types shared by the top level and the cursor unit.
// No dependencies.
package tts_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_LINES   = 64;

  // Column and line indexes, and geometry counts that can hold the maximum itself.
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int LINE_W  = $clog2(MAX_LINES);
  localparam int NCOL_W  = COL_W + 1;
  localparam int NLINE_W = LINE_W + 1;
  localparam int ADDR_W  = LINE_W + COL_W;

  // Fixed field widths of the streams and the configuration registers.
  localparam int CHAR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int NL_W       = 2;
  localparam int COLS_CFG_W = 8;
  localparam int LINES_CFG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 24;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CELL_SPACE = 7'd32;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [NL_W-1:0] NL_CR_NEWLINE = 2'd0;
  localparam logic [NL_W-1:0] NL_LF_NEWLINE = 2'd1;
  localparam logic [NL_W-1:0] NL_SPLIT      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES        = 2'd2;

  localparam logic [NL_W-1:0]        RST_NEWLINE_MODE = 2'd2;
  localparam logic [COLS_CFG_W-1:0]  RST_COLUMNS      = 8'd80;
  localparam logic [LINES_CFG_W-1:0] RST_LINES        = 7'd25;

  typedef struct packed {
    logic [LINE_W-1:0]  row;
    logic [COL_W-1:0]   col;
    logic [NLINE_W-1:0] lines_eff;
    logic [NCOL_W-1:0]  cols_eff;
    logic [NL_W-1:0]    nl_mode;
    logic [BYTE_W-1:0]  char_byte;
  } cursor_req_t;

  typedef struct packed {
    logic [LINE_W-1:0] row_sat;
    logic [COL_W-1:0]  col_sat;
    logic [LINE_W-1:0] row_new;
    logic [COL_W-1:0]  col_new;
    logic              store;
    logic              scroll;
  } cursor_rsp_t;

endpackage

>>> hdl/text_terminal_screen_unit.sv
// Text terminal screen: screen memory, line valid bits, cursor registers and
// the operation sequencer. Depends on tts_pkg and tts_cursor.
//
// Usage: each request on the s_ stream is one operation (put byte, read cell,
// clear screen or no-op) and gives exactly one result on the m_ stream, in order.
// Geometry and newline mode are written through cfg_we/cfg_index/cfg_wdata while
// no request is in flight; writes to index 3 are ignored.
// Timing: a request is taken in the idle state, executed the next cycle, and its
// result is loaded into the output register from S_OUT once that register is free
// (a read first passes S_RDWAIT, which waits for the registered memory read data).
// The next request is taken only once the sequencer is back in S_IDLE. The first
// printable byte put into a line that is blank (after reset, a clear or a
// scroll) sweeps the whole physical line of the memory through the single write
// port, in S_SWEEP.
// Only one request is worked on at a time; the output register holds a finished
// result while the next request is accepted and executed. If the receiver stalls
// with a result still held, the next result waits in the sequencer and s_tready
// stays low until the output register is free.
// Reset: the cursor and top line go to zero, the configuration to 2/80/25, and
// all line valid bits clear, so the whole screen reads as spaces at once; there
// is no clearing pass. A clear does the same for the top line and line valid bits.
module text_terminal_screen_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, from bit 0: mode[1:0], char_byte[9:2], read_row[15:10],
  // read_column[22:16], zero[23]
  input  logic [tts_pkg::S_DATA_W-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, from bit 0: cell_char[6:0], cursor_row[12:7], cursor_column[19:13],
  // did_scroll[20], zero[23:21]
  output logic [tts_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration.
  logic [tts_pkg::NL_W-1:0]        nl_mode;
  logic [tts_pkg::COLS_CFG_W-1:0]  cols_cfg;
  logic [tts_pkg::LINES_CFG_W-1:0] lines_cfg;
  logic [tts_pkg::NCOL_W-1:0]      cols_eff;
  logic [tts_pkg::NLINE_W-1:0]     lines_eff;

  // Request being worked on.
  tts_pkg::mode_t               item_mode;
  logic [tts_pkg::BYTE_W-1:0]   item_char;
  logic [tts_pkg::LINE_W-1:0]   item_row;
  logic [tts_pkg::COL_W-1:0]    item_col;

  // Screen state.
  logic [tts_pkg::LINE_W-1:0]   cursor_row_reg;
  logic [tts_pkg::COL_W-1:0]    cursor_col_reg;
  logic [tts_pkg::LINE_W-1:0]   top_line;
  logic [tts_pkg::MAX_LINES-1:0] row_valid;

  logic [tts_pkg::CHAR_W-1:0]   mem [0:tts_pkg::MAX_LINES*tts_pkg::MAX_COLUMNS-1];
  logic                         mem_we;
  logic [tts_pkg::ADDR_W-1:0]   mem_waddr;
  logic [tts_pkg::CHAR_W-1:0]   mem_wdata;
  logic [tts_pkg::ADDR_W-1:0]   mem_raddr;
  logic [tts_pkg::CHAR_W-1:0]   mem_rdata;

  // Line sweep for the first write into a blank line.
  logic [tts_pkg::COL_W-1:0]    sweep_count;
  logic [tts_pkg::LINE_W-1:0]   sweep_line;
  logic [tts_pkg::COL_W-1:0]    sweep_col;
  logic [tts_pkg::CHAR_W-1:0]   sweep_char;
  logic                         sweep_last;

  // Result waiting for the output register.
  logic [tts_pkg::CHAR_W-1:0]   res_cell;
  logic                         res_scroll;
  logic                         rd_hit;
  logic                         rd_valid;

  // Output register.
  logic [tts_pkg::CHAR_W-1:0]   out_cell;
  logic [tts_pkg::LINE_W-1:0]   out_row;
  logic [tts_pkg::COL_W-1:0]    out_col;
  logic                         out_scroll;
  logic                         load_out;

  tts_pkg::cursor_req_t         cur_req;
  tts_pkg::cursor_rsp_t         cur_rsp;
  logic [tts_pkg::LINE_W-1:0]   put_line;
  logic [tts_pkg::LINE_W-1:0]   blank_line;
  logic [tts_pkg::LINE_W-1:0]   read_line;

  tts_cursor u_cursor (
    .req (cur_req),
    .rsp (cur_rsp)
  );

  always_comb begin
    if (cols_cfg == '0) begin
      cols_eff = tts_pkg::NCOL_W'(1);
    end else if ({1'b0, cols_cfg} > (tts_pkg::COLS_CFG_W+1)'(tts_pkg::MAX_COLUMNS)) begin
      cols_eff = tts_pkg::NCOL_W'(tts_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = tts_pkg::NCOL_W'(cols_cfg);
    end
    if (lines_cfg == '0) begin
      lines_eff = tts_pkg::NLINE_W'(1);
    end else if ({1'b0, lines_cfg} > (tts_pkg::LINES_CFG_W+1)'(tts_pkg::MAX_LINES)) begin
      lines_eff = tts_pkg::NLINE_W'(tts_pkg::MAX_LINES);
    end else begin
      lines_eff = tts_pkg::NLINE_W'(lines_cfg);
    end
  end

  assign cur_req.row       = cursor_row_reg;
  assign cur_req.col       = cursor_col_reg;
  assign cur_req.lines_eff = lines_eff;
  assign cur_req.cols_eff  = cols_eff;
  assign cur_req.nl_mode   = nl_mode;
  assign cur_req.char_byte = item_char;

  // Ring arithmetic on physical lines wraps naturally at the index width.
  assign put_line   = top_line + cur_rsp.row_sat;
  assign blank_line = top_line + tts_pkg::LINE_W'(lines_eff);
  assign read_line  = top_line + item_row;
  assign mem_raddr  = {read_line, item_col};
  assign sweep_last = &sweep_count;

  assign s_tready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {put_line, cur_rsp.col_sat};
    mem_wdata = tts_pkg::CHAR_W'(item_char);
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = {sweep_line, sweep_count};
      mem_wdata = (sweep_count == sweep_col) ? sweep_char : tts_pkg::CELL_SPACE;
    end else if ((state == S_EXEC) && (item_mode == tts_pkg::MODE_PUT) && cur_rsp.store
                 && row_valid[put_line]) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_mode)
          tts_pkg::MODE_PUT: begin
            if (cur_rsp.store && !row_valid[put_line]) begin
              state_next = S_SWEEP;
            end else begin
              state_next = S_OUT;
            end
          end
          tts_pkg::MODE_READ:  state_next = S_RDWAIT;
          tts_pkg::MODE_CLEAR: state_next = S_OUT;
          tts_pkg::MODE_NOP:   state_next = S_OUT;
          default:             state_next = S_OUT;
        endcase
      end
      S_RDWAIT: state_next = S_OUT;
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      nl_mode        <= tts_pkg::RST_NEWLINE_MODE;
      cols_cfg       <= tts_pkg::RST_COLUMNS;
      lines_cfg      <= tts_pkg::RST_LINES;
      cursor_row_reg <= '0;
      cursor_col_reg <= '0;
      top_line       <= '0;
      row_valid      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          tts_pkg::CFG_NEWLINE_MODE: nl_mode   <= cfg_wdata[tts_pkg::NL_W-1:0];
          tts_pkg::CFG_COLUMNS:      cols_cfg  <= cfg_wdata[tts_pkg::COLS_CFG_W-1:0];
          tts_pkg::CFG_LINES:        lines_cfg <= cfg_wdata[tts_pkg::LINES_CFG_W-1:0];
          default: ;
        endcase
      end

      if (state == S_EXEC) begin
        if (item_mode == tts_pkg::MODE_PUT) begin
          cursor_row_reg <= cur_rsp.row_new;
          cursor_col_reg <= cur_rsp.col_new;
          if (cur_rsp.scroll) begin
            top_line              <= top_line + 1'b1;
            row_valid[blank_line] <= 1'b0;
          end
        end else begin
          cursor_row_reg <= cur_rsp.row_sat;
          cursor_col_reg <= cur_rsp.col_sat;
          if (item_mode == tts_pkg::MODE_CLEAR) begin
            top_line  <= '0;
            row_valid <= '0;
          end
        end
      end

      if ((state == S_SWEEP) && sweep_last) begin
        row_valid[sweep_line] <= 1'b1;
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_mode <= tts_pkg::mode_t'(s_tdata[1:0]);
      item_char <= s_tdata[9:2];
      item_row  <= s_tdata[15:10];
      item_col  <= s_tdata[22:16];
    end

    if (state == S_SWEEP) begin
      sweep_count <= sweep_count + 1'b1;
    end

    if (state == S_EXEC) begin
      res_cell    <= '0;
      res_scroll  <= (item_mode == tts_pkg::MODE_PUT) && cur_rsp.scroll;
      rd_hit      <= ({1'b0, item_row} < lines_eff) && ({1'b0, item_col} < cols_eff);
      rd_valid    <= row_valid[read_line];
      sweep_count <= '0;
      sweep_line  <= put_line;
      sweep_col   <= cur_rsp.col_sat;
      sweep_char  <= tts_pkg::CHAR_W'(item_char);
    end

    if (state == S_RDWAIT) begin
      if (!rd_hit) begin
        res_cell <= '0;
      end else if (rd_valid) begin
        res_cell <= mem_rdata;
      end else begin
        res_cell <= tts_pkg::CELL_SPACE;
      end
    end

    if (load_out) begin
      out_cell   <= res_cell;
      out_row    <= cursor_row_reg;
      out_col    <= cursor_col_reg;
      out_scroll <= res_scroll;
    end
  end

  assign m_tdata = {3'b000, out_scroll, out_col, out_row, out_cell};

  // After an operation executes, the cursor lies inside the area it was executed in.
  a_cursor_in_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (({1'b0, cursor_row_reg} < $past(lines_eff))
                        && ({1'b0, cursor_col_reg} < $past(cols_eff))))
    else $error("cursor left the area in use");

  // A held result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");

  // The end of a sweep marks its line as holding real contents.
  a_sweep_marks_line: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) && sweep_last) |=> row_valid[$past(sweep_line)])
    else $error("swept line not marked valid");

  // A put into a blank line never writes the memory directly.
  a_blank_line_swept: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && mem_we) |-> row_valid[mem_waddr[tts_pkg::ADDR_W-1:tts_pkg::COL_W]])
    else $error("direct write into a blank line");

endmodule

>>> hdl/tts_cursor.sv
// Cursor arithmetic for a put: saturation into the area in use, character
// handling, column wrap and scroll detection. Depends on tts_pkg.
module tts_cursor (
  input  tts_pkg::cursor_req_t req,
  output tts_pkg::cursor_rsp_t rsp
);

  logic [tts_pkg::LINE_W-1:0]  row_sat;
  logic [tts_pkg::COL_W-1:0]   col_sat;
  logic [tts_pkg::NLINE_W-1:0] row1;
  logic [tts_pkg::NCOL_W-1:0]  col1;
  logic                        printable;
  logic                        newline;
  logic                        scroll;

  always_comb begin
    // A geometry change may leave the cursor outside the area; pull it back in.
    if ({1'b0, req.row} >= req.lines_eff) begin
      row_sat = tts_pkg::LINE_W'(req.lines_eff - 1'b1);
    end else begin
      row_sat = req.row;
    end
    if ({1'b0, req.col} >= req.cols_eff) begin
      col_sat = tts_pkg::COL_W'(req.cols_eff - 1'b1);
    end else begin
      col_sat = req.col;
    end

    printable = (req.char_byte >= tts_pkg::CH_SPACE) && (req.char_byte < tts_pkg::CH_DEL);
    newline = ((req.char_byte == tts_pkg::CH_CR) && (req.nl_mode == tts_pkg::NL_CR_NEWLINE))
           || ((req.char_byte == tts_pkg::CH_LF) && (req.nl_mode == tts_pkg::NL_LF_NEWLINE));

    row1 = {1'b0, row_sat};
    col1 = {1'b0, col_sat};
    if (printable) begin
      col1 = col1 + 1'b1;
    end else if (req.char_byte == tts_pkg::CH_BS) begin
      if (col_sat != '0) begin
        col1 = col1 - 1'b1;
      end
    end else if (newline) begin
      row1 = row1 + 1'b1;
      col1 = '0;
    end else if ((req.char_byte == tts_pkg::CH_CR) && (req.nl_mode == tts_pkg::NL_SPLIT)) begin
      col1 = '0;
    end else if ((req.char_byte == tts_pkg::CH_LF) && (req.nl_mode == tts_pkg::NL_SPLIT)) begin
      row1 = row1 + 1'b1;
    end

    if (col1 >= req.cols_eff) begin
      row1 = row1 + 1'b1;
      col1 = '0;
    end
    scroll = (row1 >= req.lines_eff);
    if (scroll) begin
      row1 = req.lines_eff - 1'b1;
    end

    rsp.row_sat = row_sat;
    rsp.col_sat = col_sat;
    rsp.row_new = tts_pkg::LINE_W'(row1);
    rsp.col_new = tts_pkg::COL_W'(col1);
    rsp.store   = printable;
    rsp.scroll  = scroll;
  end

endmodule

>>> test/text_terminal_screen_checker.sv
`timescale 1ns / 1ps
// Checker for the text terminal screen. It watches the request, result and configuration
// ports, keeps its own copy of the screen, cursor and geometry, and compares every
// result with the predicted one. Depends on tts_pkg.
module text_terminal_screen_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // s_tdata, from bit 0: mode, char_byte, read_row, read_column, zero
  input  logic [tts_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata, from bit 0: cell_char, cursor_row, cursor_column, did_scroll, zero
  input  logic [tts_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                           cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             failures,
  output int                             pending
);
  import tts_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [LINE_W-1:0] row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } screen_reply_t;

  logic [CHAR_W-1:0]      cells [MAX_LINES][MAX_COLUMNS];
  int unsigned            cur_row;
  int unsigned            cur_col;
  int unsigned            top_line;
  logic [NL_W-1:0]        nl_mode;
  logic [COLS_CFG_W-1:0]  cols_cfg;
  logic [LINES_CFG_W-1:0] lines_cfg;
  screen_reply_t          expected_replies [$];

  task automatic blank_screen();
    for (int l = 0; l < MAX_LINES; l++)
      for (int c = 0; c < MAX_COLUMNS; c++)
        cells[l][c] = CELL_SPACE;
    top_line = 0;
  endtask

  task automatic apply_terminal_op(input logic [S_DATA_W-1:0] req, output screen_reply_t rep);
    mode_t             op;
    logic [BYTE_W-1:0] ch;
    int unsigned       rd_row;
    int unsigned       rd_col;
    int unsigned       ncols;
    int unsigned       nlines;
    int unsigned       bottom;
    logic [CHAR_W-1:0] cell_value;
    logic              scrolled;
    op     = mode_t'(req[1:0]);
    ch     = req[9:2];
    rd_row = req[15:10];
    rd_col = req[22:16];
    ncols  = (cols_cfg == 0) ? 1 : (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : cols_cfg;
    nlines = (lines_cfg == 0) ? 1 : (lines_cfg > MAX_LINES) ? MAX_LINES : lines_cfg;
    cell_value = '0;
    scrolled   = 1'b0;
    // A geometry change can leave the cursor outside the area in use.
    if (cur_row >= nlines) cur_row = nlines - 1;
    if (cur_col >= ncols) cur_col = ncols - 1;
    case (op)
      MODE_PUT: begin
        if (ch >= CH_SPACE && ch < CH_DEL) begin
          cells[(top_line + cur_row) % MAX_LINES][cur_col] = ch[CHAR_W-1:0];
          cur_col++;
        end else if (ch == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if ((ch == CH_CR && nl_mode == NL_CR_NEWLINE) ||
                     (ch == CH_LF && nl_mode == NL_LF_NEWLINE)) begin
          cur_row++;
          cur_col = 0;
        end else if (ch == CH_CR && nl_mode == NL_SPLIT) begin
          cur_col = 0;
        end else if (ch == CH_LF && nl_mode == NL_SPLIT) begin
          cur_row++;
        end
        if (cur_col >= ncols) begin
          cur_row++;
          cur_col = 0;
        end
        if (cur_row >= nlines) begin
          // The top line moves down the ring and the new bottom line is blanked whole.
          top_line = (top_line + 1) % MAX_LINES;
          bottom   = (top_line + nlines - 1) % MAX_LINES;
          for (int c = 0; c < MAX_COLUMNS; c++)
            cells[bottom][c] = CELL_SPACE;
          cur_row  = nlines - 1;
          scrolled = 1'b1;
        end
      end
      MODE_READ: begin
        if (rd_row < nlines && rd_col < ncols)
          cell_value = cells[(top_line + rd_row) % MAX_LINES][rd_col];
      end
      MODE_CLEAR: blank_screen();
      default: begin
      end
    endcase
    rep.cell_char = cell_value;
    rep.row       = cur_row[LINE_W-1:0];
    rep.col       = cur_col[COL_W-1:0];
    rep.scrolled  = scrolled;
  endtask

  always @(posedge clk) begin : monitor
    screen_reply_t got;
    screen_reply_t want;
    if (rst) begin
      blank_screen();
      cur_row   = 0;
      cur_col   = 0;
      nl_mode   = RST_NEWLINE_MODE;
      cols_cfg  = RST_COLUMNS;
      lines_cfg = RST_LINES;
      expected_replies.delete();
      failures  = 0;
    end else begin
      // A result leaving at this edge always belongs to an earlier request.
      if (m_tvalid && m_tready) begin
        got.cell_char = m_tdata[6:0];
        got.row       = m_tdata[12:7];
        got.col       = m_tdata[19:13];
        got.scrolled  = m_tdata[20];
        if (expected_replies.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result %h arrived with no request outstanding",
                     $realtime, m_tdata);
        end else begin
          want = expected_replies.pop_front();
          if (got.cell_char !== want.cell_char || got.row !== want.row ||
              got.col !== want.col || got.scrolled !== want.scrolled) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: mismatch: expected char %0d row %0d col %0d scroll %0d,",
                        " got char %0d row %0d col %0d scroll %0d"},
                       $realtime, want.cell_char, want.row, want.col, want.scrolled,
                       got.cell_char, got.row, got.col, got.scrolled);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_terminal_op(s_tdata, want);
        expected_replies.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEWLINE_MODE: nl_mode   = cfg_wdata[NL_W-1:0];
          CFG_COLUMNS:      cols_cfg  = cfg_wdata[COLS_CFG_W-1:0];
          CFG_LINES:        lines_cfg = cfg_wdata[LINES_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> test/text_terminal_screen_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for text_terminal_screen_unit: drives requests, configuration writes and
// result back-pressure, and gives the verdict. Depends on tts_pkg and
// text_terminal_screen_checker.
module text_terminal_screen_unit_tb;
  import tts_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES          = 9;
  localparam int SETTLE_CYCLES   = MAX_COLUMNS + 16;

  localparam logic [NL_W-1:0]      NL_IGNORE        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    failures;
  int                    pending;
  int                    idle_cycles;
  int                    burst_left;
  int                    ready_run;
  int                    stall_run;
  // Effective geometry, used to aim most reads at the area in use.
  int unsigned           cols_now;
  int unsigned           lines_now;

  text_terminal_screen_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  text_terminal_screen_checker checker_inst (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [S_DATA_W-1:0] pack_request(input mode_t op,
                                                       input logic [BYTE_W-1:0] ch,
                                                       input logic [LINE_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
    return {1'b0, col, row, ch, op};
  endfunction

  function automatic logic [S_DATA_W-1:0] random_request();
    int unsigned       pick;
    mode_t             op;
    logic [BYTE_W-1:0] ch;
    logic [LINE_W-1:0] row;
    logic [COL_W-1:0]  col;
    pick = $urandom_range(99);
    op   = MODE_PUT;
    ch   = BYTE_W'($urandom);
    row  = LINE_W'($urandom);
    col  = COL_W'($urandom);
    if (pick < 55) begin
      ch = BYTE_W'($urandom_range(126, 32));
    end else if (pick < 63) begin
      case ($urandom_range(2))
        0:       ch = CH_BS;
        1:       ch = CH_CR;
        default: ch = CH_LF;
      endcase
    end else if (pick < 83) begin
      op  = MODE_READ;
      row = LINE_W'($urandom_range(lines_now - 1));
      col = COL_W'($urandom_range(cols_now - 1));
    end else if (pick < 88) begin
      op = MODE_READ;
    end else if (pick < 90) begin
      op = MODE_CLEAR;
    end else if (pick < 95) begin
      op = MODE_NOP;
    end
    // Otherwise a put of an arbitrary byte, mostly one that is ignored.
    return pack_request(op, ch, row, col);
  endfunction

  // Starts at a falling edge and returns at the falling edge after the request is taken.
  task automatic send_request(input logic [S_DATA_W-1:0] req);
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    do begin
      @(posedge clk);
    end while (!s_tready);
    @(negedge clk);
  endtask

  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [NL_W-1:0] nl, input logic [COLS_CFG_W-1:0] cols,
                              input logic [LINES_CFG_W-1:0] lines);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    wait_drained();
    // The bench idles between the last result and the register writes.
    repeat (4) @(negedge clk);
    // Bits above the newline-mode and lines registers' widths are filled with noise; they must be dropped.
    write_register(CFG_NEWLINE_MODE, {noise[7:2], nl});
    write_register(CFG_COLUMNS, cols);
    write_register(CFG_LINES, {noise[1], lines});
    write_register(CFG_UNUSED_INDEX, noise);
    cfg_we    <= 1'b0;
    cols_now  = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
    lines_now = (lines == 0) ? 1 : (lines > MAX_LINES) ? MAX_LINES : lines;
  endtask

  always @(negedge clk) begin : result_backpressure
    logic ready_next;
    if (ready_run > 0) begin
      ready_run--;
      ready_next = 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      ready_next = 1'b0;
    end else begin
      ready_run  = $urandom_range(40, 1);
      stall_run  = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
      ready_next = 1'b1;
    end
    m_tready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("text_terminal_screen_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [S_DATA_W-1:0] directed [$];
    int                  pause_at;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    burst_left  = 0;
    cols_now    = RST_COLUMNS;
    lines_now   = RST_LINES;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: 80 columns, 25 lines, CR returns and LF advances.
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, 8'h41, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, CH_SPACE, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, 8'd126, 6'd63, 7'd127));
    directed.push_back(pack_request(MODE_PUT, CH_DEL, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, 8'd255, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, 8'd0, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, 8'd128, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, CH_BS, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, CH_CR, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_PUT, CH_LF, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_READ, 8'hFF, 6'd0, 7'd2));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd63, 7'd127));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd24, 7'd80));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd25, 7'd0));
    directed.push_back(pack_request(MODE_NOP, 8'hFF, 6'd63, 7'd127));
    // Backspace with the cursor already at column 0.
    directed.push_back(pack_request(MODE_PUT, CH_BS, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_CLEAR, 8'hFF, 6'd63, 7'd127));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd0, 7'd0));
    directed.push_back(pack_request(MODE_READ, 8'h00, 6'd0, 7'd79));
    foreach (directed[i]) begin
      sender_pace();
      send_request(directed[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
        end
        1:       set_geometry(NL_CR_NEWLINE, 8'd1, 7'd1);
        2:       set_geometry(NL_LF_NEWLINE, 8'd128, 7'd64);
        3:       set_geometry(NL_SPLIT, 8'd0, 7'd0);
        4:       set_geometry(NL_IGNORE, 8'd255, 7'd127);
        5:       set_geometry(NL_SPLIT, 8'd5, 7'd3);
        default: set_geometry(NL_W'($urandom_range(3)), COLS_CFG_W'($urandom_range(12, 1)),
                              LINES_CFG_W'($urandom_range(6, 1)));
      endcase
      pause_at = $urandom_range(ITEMS_PER_PHASE - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sender_pace();
        // Once per phase, hold the next request back until the block has handed over all its results.
        if (i == pause_at)
          wait_drained();
        send_request(random_request());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("text_terminal_screen_unit_tb: PASS");
    else
      $display("text_terminal_screen_unit_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/tts_pkg.sv
hdl/tts_cursor.sv
hdl/text_terminal_screen_unit.sv
test/text_terminal_screen_checker.sv
test/text_terminal_screen_unit_tb.sv
